>>> src/point_stack_with_search_defines.svh
// assertion helpers for the point stack
`ifndef POINT_STACK_WITH_SEARCH_DEFINES_SVH
`define POINT_STACK_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, checked on the block clock outside reset
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on the block clock outside reset
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pss_pkg.sv
`timescale 1ns / 1ps
package pss_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int COORD_W     = 8;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// coordinate returned by pop or peek on an empty stack (-1)
	localparam logic [COORD_W-1:0] NONE_VALUE = '1;

	typedef struct packed {
		logic load_in;
		logic rd_en;
		logic rd_top;
		logic scan_first;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            hit;
		logic            last;
		logic            out_free;
	} stat_t;

endpackage

>>> src/pss_ctrl.sv
`timescale 1ns / 1ps
module pss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pss_pkg::stat_t stat,
	output pss_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCAN
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op) inside
					pss_pkg::OP_POP, pss_pkg::OP_PEEK: begin
						if (!stat.empty) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_top = 1'b1;
							state_d    = S_READ;
						end else if (stat.out_free) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end
					end
					pss_pkg::OP_SEARCH: begin
						if (!stat.empty) begin
							cmd.rd_en      = 1'b1;
							cmd.scan_first = 1'b1;
							state_d        = S_SCAN;
						end else if (stat.out_free) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end
					end
					default: begin
						if (stat.out_free) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end
					end
				endcase
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SCAN: begin
				// read data holds while the result waits for the output slot
				if (stat.hit || stat.last) begin
					if (stat.out_free) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule

>>> src/pss_dpath.sv
`timescale 1ns / 1ps
module pss_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pss_pkg::cmd_t                       cmd,
	output pss_pkg::stat_t                      stat,
	input  logic [pss_pkg::OP_W-1:0]            opcode,
	input  logic signed [pss_pkg::COORD_W-1:0]  point_x,
	input  logic signed [pss_pkg::COORD_W-1:0]  point_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pss_pkg::COORD_W-1:0]  out_x,
	output logic signed [pss_pkg::COORD_W-1:0]  out_y,
	output logic                                found,
	output logic [pss_pkg::STATUS_W-1:0]        status,
	output logic                                is_empty
);

	localparam int PAIR_W = 2 * pss_pkg::COORD_W;

	logic [pss_pkg::OP_W-1:0]    op_q;
	logic [pss_pkg::COORD_W-1:0] px_q, py_q;
	logic [pss_pkg::CNT_W-1:0]   fill_q, fill_d, top_cnt;
	logic [PAIR_W-1:0]           mem [pss_pkg::STACK_DEPTH];
	logic [PAIR_W-1:0]           rd_data_q;
	logic [pss_pkg::ADDR_W-1:0]  rd_idx_q, rd_addr;
	logic                        empty, full, hit, last, wr_en;

	logic [pss_pkg::COORD_W-1:0]  res_x, res_y;
	logic                         res_found;
	logic [pss_pkg::STATUS_W-1:0] res_status;

	logic                         out_valid_q;
	logic [pss_pkg::COORD_W-1:0]  out_x_q, out_y_q;
	logic                         found_q, is_empty_q;
	logic [pss_pkg::STATUS_W-1:0] status_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode;
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	assign top_cnt = fill_q - pss_pkg::CNT_W'(1);
	assign empty   = (fill_q == '0);
	assign full    = (fill_q == pss_pkg::CNT_W'(pss_pkg::STACK_DEPTH));
	assign hit     = (rd_data_q == {py_q, px_q});
	assign last    = (pss_pkg::CNT_W'(rd_idx_q) == top_cnt);

	// scan walks from the bottom entry upward, one read per cycle
	always_comb begin
		if (cmd.rd_top)
			rd_addr = top_cnt[pss_pkg::ADDR_W-1:0];
		else if (cmd.scan_first)
			rd_addr = '0;
		else
			rd_addr = rd_idx_q + pss_pkg::ADDR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && wr_en)
			mem[fill_q[pss_pkg::ADDR_W-1:0]] <= {py_q, px_q};
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_idx_q  <= rd_addr;
		end
	end

	always_comb begin
		res_x      = '0;
		res_y      = '0;
		res_found  = 1'b0;
		res_status = pss_pkg::ST_OK;
		fill_d     = fill_q;
		wr_en      = 1'b0;
		case (op_q) inside
			pss_pkg::OP_PUSH: begin
				if (full) begin
					res_status = pss_pkg::ST_FULL;
				end else begin
					wr_en  = 1'b1;
					fill_d = fill_q + pss_pkg::CNT_W'(1);
				end
			end
			pss_pkg::OP_POP, pss_pkg::OP_PEEK: begin
				if (empty) begin
					res_x      = pss_pkg::NONE_VALUE;
					res_y      = pss_pkg::NONE_VALUE;
					res_status = pss_pkg::ST_EMPTY;
				end else begin
					res_x = rd_data_q[pss_pkg::COORD_W-1:0];
					res_y = rd_data_q[PAIR_W-1:pss_pkg::COORD_W];
					if (op_q == pss_pkg::OP_POP)
						fill_d = top_cnt;
				end
			end
			pss_pkg::OP_CLEAR: fill_d = '0;
			pss_pkg::OP_SEARCH: res_found = !empty && hit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				fill_q <= fill_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_x_q    <= res_x;
			out_y_q    <= res_y;
			found_q    <= res_found;
			status_q   <= res_status;
			is_empty_q <= (fill_d == '0);
		end
	end

	assign stat.op       = op_q;
	assign stat.empty    = empty;
	assign stat.hit      = hit;
	assign stat.last     = last;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign found     = found_q;
	assign status    = status_q;
	assign is_empty  = is_empty_q;

endmodule

>>> src/point_stack_with_search.sv
`timescale 1ns / 1ps
// point stack with membership search: a lifo of up to 128 signed (x, y) pairs held in a
// single-port-read memory. each request carries an opcode in s_tuser and gets exactly one
// response. requests are handled one at a time: push, clear and unknown opcodes finish in the
// execute state; pop and peek go through one registered memory read of the top entry, except
// on an empty stack, where they finish in the execute state. search on an empty stack does
// the same, otherwise the memory read port scans the stored pairs one per cycle from the
// bottom and stops at the first match or at the top entry. the next request is accepted in the
// cycle after the response register loads. a finished response waits in the output register
// while the next request is accepted; a response can load only once the previous one has been
// taken or is taken in that same cycle, so an output stall holds the block until the slot frees.
// after reset the stack is empty and ready at once; a push on a full stack is dropped with status
// full, a pop or peek on an empty stack returns -1, -1 with status empty.
`include "point_stack_with_search_defines.svh"
module point_stack_with_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // point_x[7:0], point_y[15:8]
	input  logic [2:0]  s_tuser,  // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_x[7:0], out_y[15:8], found[16], is_empty[17], zero
	output logic [1:0]  m_tuser   // status[1:0]
);

	pss_pkg::cmd_t  cmd;
	pss_pkg::stat_t stat;

	logic signed [pss_pkg::COORD_W-1:0] out_x, out_y;
	logic                               found, is_empty;

	pss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pss_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (s_tuser),
		.point_x   (s_tdata[7:0]),
		.point_y   (s_tdata[15:8]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_x     (out_x),
		.out_y     (out_y),
		.found     (found),
		.status    (m_tuser),
		.is_empty  (is_empty)
	);

	assign m_tdata = {6'b0, is_empty, found, out_y, out_x};

	`PSS_ASSERT_NOW(a_finish_has_slot, cmd.finish, stat.out_free, "response lost: output busy")
	`PSS_ASSERT_NOW(a_no_read_on_finish, cmd.finish, !cmd.rd_en, "read issued while finishing")
	`PSS_ASSERT_NEXT(a_finish_shows, cmd.finish, m_tvalid, "finished response not presented")
	`PSS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pss_pkg::*;

	localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = STACK_DEPTH + 20;
	localparam int MAX_REPORTS    = 10;
	localparam int FILL_PUSHES    = STACK_DEPTH + 7;
	localparam int POP_RUN        = STACK_DEPTH + 12;
	localparam int MIXED_RUN      = 260;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} stack_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic                      found;
		logic [STATUS_W-1:0]       status;
		logic                      is_empty;
	} stack_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // point_x[7:0], point_y[15:8]
	logic [2:0]  s_tuser;   // opcode[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // out_x[7:0], out_y[15:8], found[16], is_empty[17], zero
	logic [1:0]  m_tuser;   // status[1:0]

	point_stack_with_search DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow copy of the stack
	logic [COORD_W-1:0] held_x [STACK_DEPTH];
	logic [COORD_W-1:0] held_y [STACK_DEPTH];
	int                 held_count;

	stack_req_t pending_requests[$];
	stack_rsp_t expected_replies[$];
	logic [15:0] recent_pairs[$];
	stack_req_t next_req;

	int  tx_idle_pct;
	int  rx_idle_pct;
	bit  req_taken;
	int  queued_count;
	int  accepted_count;
	int  checked_count;
	int  mismatch_count;
	int  full_drops;
	int  empty_reads;
	int  search_hits;
	int  quiet_cycles;

	always #5 clk = ~clk;

	function automatic stack_rsp_t predict_stack_op(input stack_req_t r);
		stack_rsp_t rsp;
		rsp = '0;
		rsp.status = ST_OK;
		case (r.op)
			OP_PUSH: begin
				if (held_count >= STACK_DEPTH) begin
					rsp.status = ST_FULL;
					full_drops++;
				end else begin
					held_x[held_count] = r.x;
					held_y[held_count] = r.y;
					held_count++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (held_count == 0) begin
					rsp.out_x = NONE_VALUE;
					rsp.out_y = NONE_VALUE;
					rsp.status = ST_EMPTY;
					empty_reads++;
				end else begin
					rsp.out_x = held_x[held_count - 1];
					rsp.out_y = held_y[held_count - 1];
					if (r.op == OP_POP)
						held_count--;
				end
			end
			OP_CLEAR: held_count = 0;
			OP_SEARCH: begin
				for (int i = 0; i < held_count; i++)
					if (held_x[i] == r.x && held_y[i] == r.y)
						rsp.found = 1'b1;
				if (rsp.found)
					search_hits++;
			end
			default: ;
		endcase
		rsp.is_empty = (held_count == 0);
		return rsp;
	endfunction

	task automatic queue_req(input logic [OP_W-1:0] op, input logic [7:0] x,
			input logic [7:0] y);
		stack_req_t r;
		r.op = op;
		r.x = x;
		r.y = y;
		pending_requests.push_back(r);
		queued_count++;
		if (op == OP_PUSH) begin
			recent_pairs.push_back({y, x});
			if (recent_pairs.size() > 32)
				void'(recent_pairs.pop_front());
		end
	endtask

	// corners and a small window around zero show up often so searches can hit
	function automatic logic [7:0] pick_coord();
		case ($urandom_range(5))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'($urandom_range(4)) - 8'd2;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_push();
		queue_req(OP_PUSH, pick_coord(), pick_coord());
	endtask

	task automatic queue_search();
		logic [15:0] pair;
		if (recent_pairs.size() != 0 && $urandom_range(99) < 60)
			pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
		else
			pair = {pick_coord(), pick_coord()};
		queue_req(OP_SEARCH, pair[7:0], pair[15:8]);
	endtask

	task automatic queue_mixed();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			queue_push();
		else if (pick < 55)
			queue_req(OP_POP, 8'($urandom), 8'($urandom));
		else if (pick < 65)
			queue_req(OP_PEEK, 8'($urandom), 8'($urandom));
		else if (pick < 92)
			queue_search();
		else if (pick < 95)
			queue_req(OP_CLEAR, 8'($urandom), 8'($urandom));
		else
			queue_req(3'($urandom_range(OP_RSVD_A, OP_RSVD_C)), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_all_done();
		while (accepted_count != queued_count || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_phase(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		queue_req(OP_CLEAR, 8'h00, 8'h00);
		// fill past the top so pushes get dropped, with searches mixed in
		for (int i = 0; i < FILL_PUSHES; i++) begin
			queue_push();
			if ($urandom_range(7) == 0)
				queue_search();
		end
		// pop and peek the stack down from full
		for (int i = 0; i < POP_RUN; i++) begin
			if ($urandom_range(5) == 0)
				queue_req(OP_PEEK, 8'($urandom), 8'($urandom));
			else
				queue_req(OP_POP, 8'($urandom), 8'($urandom));
		end
		for (int i = 0; i < MIXED_RUN; i++)
			queue_mixed();
		wait_all_done();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		held_count = 0;
		tx_idle_pct = 24;
		rx_idle_pct = 56;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		queue_req(OP_PEEK, 8'h00, 8'h00);
		queue_req(OP_POP, 8'hFF, 8'hFF);
		queue_req(OP_CLEAR, 8'h00, 8'h00);
		queue_req(OP_SEARCH, 8'h80, 8'h80);
		queue_req(OP_PUSH, 8'h7F, 8'h80);
		queue_req(OP_PUSH, 8'h80, 8'h7F);
		queue_req(OP_PUSH, 8'hFF, 8'hFF);
		queue_req(OP_PUSH, 8'h00, 8'h00);
		queue_req(OP_PEEK, 8'h55, 8'hAA);
		queue_req(OP_SEARCH, 8'h80, 8'h7F);
		queue_req(OP_SEARCH, 8'h7F, 8'h7F);
		queue_req(OP_SEARCH, 8'hFF, 8'hFF);
		queue_req(OP_POP, 8'h00, 8'h00);
		queue_req(OP_POP, 8'h00, 8'h00);
		queue_req(OP_RSVD_A, 8'hAA, 8'h55);
		queue_req(OP_RSVD_B, 8'hFF, 8'hFF);
		queue_req(OP_RSVD_C, 8'h80, 8'h7F);
		queue_req(OP_SEARCH, 8'h7F, 8'h80);
		queue_req(OP_CLEAR, 8'hFF, 8'hFF);
		queue_req(OP_PEEK, 8'h00, 8'h00);
		queue_req(OP_PUSH, 8'h55, 8'hAA);
		queue_req(OP_SEARCH, 8'h55, 8'hAA);
		queue_req(OP_POP, 8'h00, 8'h00);
		queue_req(OP_POP, 8'h00, 8'h00);
		wait_all_done();

		run_random_phase(24, 56);
		run_random_phase(56, 24);
		run_random_phase(0, 0);

		// anything arriving now is unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$display("%0d responses never arrived", expected_replies.size());
			mismatch_count += expected_replies.size();
		end
		$display("%0d requests over every opcode, %0d responses checked, three idle patterns",
			accepted_count, checked_count);
		$display("%0d full-stack push drops, %0d empty-stack reads, %0d search hits",
			full_drops, empty_reads, search_hits);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || req_taken) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_req.y, next_req.x};
					s_tuser <= next_req.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// acceptance, prediction and response check
	always @(posedge clk) begin : check_blk
		stack_req_t seen;
		stack_rsp_t want;
		stack_rsp_t got;
		req_taken = arst_n && s_tvalid && s_tready;
		if (req_taken) begin
			seen.op = s_tuser;
			seen.x = s_tdata[7:0];
			seen.y = s_tdata[15:8];
			expected_replies.push_back(predict_stack_op(seen));
			accepted_count++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.out_x = m_tdata[7:0];
			got.out_y = m_tdata[15:8];
			got.found = m_tdata[16];
			got.is_empty = m_tdata[17];
			got.status = m_tuser;
			if (expected_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected response x=%0d y=%0d found=%0b status=%0d empty=%0b",
						got.out_x, got.out_y, got.found, got.status, got.is_empty);
			end else begin
				want = expected_replies.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$write("response %0d: expected x=%0d y=%0d found=%0b status=%0d ",
							checked_count, want.out_x, want.out_y, want.found, want.status);
						$display("empty=%0b, got x=%0d y=%0d found=%0b status=%0d empty=%0b",
							want.is_empty, got.out_x, got.out_y, got.found, got.status,
							got.is_empty);
					end
				end
			end
			checked_count++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no request or response moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

endmodule

>>> files.f
+incdir+src
src/pss_pkg.sv
src/pss_ctrl.sv
src/pss_dpath.sv
src/point_stack_with_search.sv
tb/testbench.sv
